FILE: hw/rtl/selective_repeat_reorder_receiver_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the selective-repeat reorder receiver
// Shared concurrent property forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_REORDER_RECEIVER_CORE_DEFINES_SVH
`define SELECTIVE_REPEAT_REORDER_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication
`define SRR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srr: same-cycle check failed");

// Next-cycle implication
`define SRR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srr: next-cycle check failed");

`endif

FILE: hw/rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Widths, result kinds and slot-store interface types for the reorder receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

    // Receive window: slot index is the low bits of the sequence number
    localparam int SLOTS   = 32;
    localparam int SLOT_IW = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);

    // Field widths
    localparam int SEQ_W = 8;
    localparam int LEN_W = 10;
    localparam int HDL_W = 8;
    localparam int WIN_W = 6;

    localparam logic [SEQ_W-1:0] SLOTS_SEQ    = SEQ_W'(SLOTS);
    localparam logic [WIN_W-1:0] WIN_MAX      = 6'd63;
    localparam logic [WIN_W-1:0] INIT_WIN_RST = 6'd31;

    // APB register map
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_INIT_WIN = 1'b0;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_NACK    = 2'd2,
        KIND_END     = 2'd3
    } t_kind;

    // Slot store request
    typedef struct packed {
        logic               wr;
        logic               rd;
        logic               clr;
        logic [SLOT_IW-1:0] idx;
    } t_slot_ctl;

    // Slot payload, tagged with the full sequence number
    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [HDL_W-1:0] hdl;
    } t_slot_data;

    // Slot store status
    typedef struct packed {
        logic used;
        logic full;
    } t_slot_sts;

endpackage

FILE: hw/rtl/selective_repeat_reorder_receiver_core.sv
// ----------------------------------------------------------------------------
// selective_repeat_reorder_receiver_core
// Selective-repeat receive window with in-order payload delivery.
// ----------------------------------------------------------------------------
// One packet descriptor is taken at a time; s_axis_tready is low until its
// last result has been loaded into the output register. A corrupt packet is
// accepted and then answered with a NACK. A good packet is accepted and
// evaluated, then the expected number is looked up; each payload delivered
// from the slot store takes one slot-memory read, then the delivery. A packet
// that is itself next in order is delivered first while the store has room,
// and a slot of the expected number that holds the packet a full window ahead
// costs one more read before the ACK. Output back-pressure can stall any step
// that loads a result. Stored packets sit in the slot indexed by the low bits
// of their sequence number, so each in-order lookup is a single read of the
// one-port slot memory. Once a zero-length packet has been delivered, further
// packets are accepted and give no result until reset.
// ----------------------------------------------------------------------------
module selective_repeat_reorder_receiver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Packet descriptors
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // seq_number[7:0], payload_length[17:8],
                                       // payload_handle[25:18], zero[31:26]
    input  logic [0:0]  s_axis_tuser,  // decode_ok[0]
    // Results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // ack_seq[7:0], window_adv[13:8],
                                       // out_length[23:14], out_handle[31:24]
    output logic [1:0]  m_axis_tuser,  // kind[1:0]
    output logic        m_axis_tlast,
    // Configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [srr_pkg::APB_AW-1:0] paddr,
    input  logic [srr_pkg::APB_DW-1:0] pwdata,
    output logic [srr_pkg::APB_DW-1:0] prdata,
    output logic                     pready
);
    import srr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_HELD  = 6'b000100,
        S_ISSUE = 6'b001000,
        S_DLV   = 6'b010000,
        S_ACK   = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic             r_ok, n_ok;
    logic [SEQ_W-1:0] r_seq, n_seq;
    logic [LEN_W-1:0] r_len, n_len;
    logic [HDL_W-1:0] r_hdl, n_hdl;
    logic [SEQ_W-1:0] r_exp, n_exp;
    logic [WIN_W-1:0] r_win, n_win;
    logic [WIN_W-1:0] r_init_win, n_init_win;
    logic             r_fin, n_fin;

    logic             r_ovalid, n_ovalid;
    t_kind            r_okind, n_okind;
    logic [SEQ_W-1:0] r_oseq, n_oseq;
    logic [WIN_W-1:0] r_owin, n_owin;
    logic [LEN_W-1:0] r_olen, n_olen;
    logic [HDL_W-1:0] r_ohdl, n_ohdl;
    logic             r_olast, n_olast;

    t_slot_ctl        slot_ctl;
    t_slot_data       slot_wdata;
    t_slot_data       slot_rdata;
    t_slot_sts        slot_sts;

    logic             out_free;
    logic             cfg_wr;
    logic [SEQ_W-1:0] seq_ahead;
    logic [WIN_W-1:0] win_dec, win_inc;

    srr_slots u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (slot_ctl),
        .i_wdata (slot_wdata),
        .o_rdata (slot_rdata),
        .o_sts   (slot_sts)
    );

    // Shared window and distance arithmetic
    assign seq_ahead = r_seq - r_exp;
    assign win_dec   = (r_win == '0) ? r_win : r_win - WIN_W'(1);
    assign win_inc   = (r_win == WIN_MAX) ? r_win : r_win + WIN_W'(1);
    assign out_free  = !r_ovalid || m_axis_tready;
    assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == REG_INIT_WIN);

    assign slot_wdata.seq = r_seq;
    assign slot_wdata.len = r_len;
    assign slot_wdata.hdl = r_hdl;

    // Sequencer: evaluate, NACK corrupt packets, deliver in order, acknowledge
    always_comb begin
        n_state    = r_state;
        n_ok       = r_ok;
        n_seq      = r_seq;
        n_len      = r_len;
        n_hdl      = r_hdl;
        n_exp      = r_exp;
        n_win      = r_win;
        n_init_win = r_init_win;
        n_fin      = r_fin;

        slot_ctl     = '0;
        slot_ctl.idx = r_exp[SLOT_IW-1:0];

        n_ovalid = r_ovalid && !m_axis_tready;
        n_okind  = r_okind;
        n_oseq   = r_oseq;
        n_owin   = r_owin;
        n_olen   = r_olen;
        n_ohdl   = r_ohdl;
        n_olast  = r_olast;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_ok  = s_axis_tuser[0];
                    n_seq = s_axis_tdata[7:0];
                    n_len = s_axis_tdata[17:8];
                    n_hdl = s_axis_tdata[25:18];
                    if (!r_fin) begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                slot_ctl.idx = r_seq[SLOT_IW-1:0];
                if (!r_ok) begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_okind  = KIND_NACK;
                        n_oseq   = r_seq;
                        n_owin   = r_win;
                        n_olen   = '0;
                        n_ohdl   = '0;
                        n_olast  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (seq_ahead == '0) begin
                    // Next in order: hold it aside and deliver it first unless the store is full
                    if (!slot_sts.full) begin
                        n_win   = win_dec;
                        n_state = S_HELD;
                    end else begin
                        n_state = S_ISSUE;
                    end
                end else begin
                    // Store inside the window unless already held
                    if ((seq_ahead <= SLOTS_SEQ) && !slot_sts.used) begin
                        slot_ctl.wr = 1'b1;
                        n_win       = win_dec;
                    end
                    n_state = S_ISSUE;
                end
            end
            S_HELD: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oseq   = r_exp;
                    n_owin   = '0;
                    n_olast  = 1'b0;
                    n_win    = win_inc;
                    n_exp    = r_exp + SEQ_W'(1);
                    if (r_len == '0) begin
                        n_okind = KIND_END;
                        n_olen  = '0;
                        n_ohdl  = '0;
                        n_fin   = 1'b1;
                        n_state = S_ACK;
                    end else begin
                        n_okind = KIND_DELIVER;
                        n_olen  = r_len;
                        n_ohdl  = r_hdl;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                // Look up the expected number; read its payload if present
                if (slot_sts.used) begin
                    slot_ctl.rd = 1'b1;
                    n_state     = S_DLV;
                end else begin
                    n_state = S_ACK;
                end
            end
            S_DLV: begin
                if (slot_rdata.seq != r_exp) begin
                    // Slot holds the packet a full window ahead: leave it stored
                    n_state = S_ACK;
                end else if (out_free) begin
                    slot_ctl.clr = 1'b1;
                    n_ovalid     = 1'b1;
                    n_oseq       = r_exp;
                    n_owin       = '0;
                    n_olast      = 1'b0;
                    n_win        = win_inc;
                    n_exp        = r_exp + SEQ_W'(1);
                    if (slot_rdata.len == '0) begin
                        n_okind = KIND_END;
                        n_olen  = '0;
                        n_ohdl  = '0;
                        n_fin   = 1'b1;
                        n_state = S_ACK;
                    end else begin
                        n_okind = KIND_DELIVER;
                        n_olen  = slot_rdata.len;
                        n_ohdl  = slot_rdata.hdl;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ACK: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_ACK;
                    n_oseq   = r_exp;
                    n_owin   = r_win;
                    n_olen   = '0;
                    n_ohdl   = '0;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Register write reloads the window count as well
        if (cfg_wr) begin
            n_init_win = pwdata[WIN_W-1:0];
            n_win      = pwdata[WIN_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_exp      <= '0;
            r_win      <= INIT_WIN_RST;
            r_init_win <= INIT_WIN_RST;
            r_fin      <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_exp      <= n_exp;
            r_win      <= n_win;
            r_init_win <= n_init_win;
            r_fin      <= n_fin;
            r_ovalid   <= n_ovalid;
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        r_ok    <= n_ok;
        r_seq   <= n_seq;
        r_len   <= n_len;
        r_hdl   <= n_hdl;
        r_okind <= n_okind;
        r_oseq  <= n_oseq;
        r_owin  <= n_owin;
        r_olen  <= n_olen;
        r_ohdl  <= n_ohdl;
        r_olast <= n_olast;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_ohdl, r_olen, r_owin, r_oseq};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INIT_WIN) ? APB_DW'(r_init_win) : '0;

endmodule

FILE: hw/rtl/srr_slots.sv
// ----------------------------------------------------------------------------
// srr_slots
// Direct-mapped packet slot store: payload memory, occupancy bits and count.
// ----------------------------------------------------------------------------
module srr_slots (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srr_pkg::t_slot_ctl  i_ctl,
    input  srr_pkg::t_slot_data i_wdata,
    output srr_pkg::t_slot_data o_rdata,
    output srr_pkg::t_slot_sts  o_sts
);
    import srr_pkg::*;

    t_slot_data         r_mem [SLOTS];
    t_slot_data         r_rdata;
    logic [SLOTS-1:0]   r_used, n_used;
    logic [CNT_W-1:0]   r_count, n_count;

    // Payload memory: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_ctl.idx] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_ctl.idx];
        end
    end

    // Mark a slot on store, free it on delivery
    always_comb begin
        n_used  = r_used;
        n_count = r_count;
        if (i_ctl.wr) begin
            n_used[i_ctl.idx] = 1'b1;
            n_count           = r_count + CNT_W'(1);
        end else if (i_ctl.clr) begin
            n_used[i_ctl.idx] = 1'b0;
            n_count           = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
        end else begin
            r_used  <= n_used;
            r_count <= n_count;
        end
    end

    assign o_rdata   = r_rdata;
    assign o_sts.used = r_used[i_ctl.idx];
    assign o_sts.full = (r_count == CNT_W'(SLOTS));

endmodule

FILE: hw/rtl/srr_chk.sv
// ----------------------------------------------------------------------------
// srr_chk
// Port-level checks for the reorder receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "selective_repeat_reorder_receiver_core_defines.svh"

module srr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import srr_pkg::*;

    logic        out_wait;
    logic        end_take;
    logic        ack_shown;
    logic        res_closes;
    logic [34:0] out_word;

    assign out_wait   = m_axis_tvalid && !m_axis_tready;
    assign end_take   = m_axis_tvalid && m_axis_tready && (m_axis_tuser == KIND_END);
    assign ack_shown  = m_axis_tvalid && (m_axis_tuser == KIND_ACK);
    assign res_closes = (m_axis_tuser == KIND_ACK) || (m_axis_tuser == KIND_NACK);
    assign out_word   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

    // Hold a stalled result
    `SRR_ASSERT_NXT(a_out_hold, out_wait, m_axis_tvalid && $stable(out_word))

    // Acknowledgements close a request, deliveries never do
    `SRR_ASSERT_IMP(a_last_kind, m_axis_tvalid, m_axis_tlast == res_closes)

    // End of transfer is followed at once by the closing ACK
    `SRR_ASSERT_NXT(a_end_then_ack, end_take, ack_shown)

    // No new request while a request still has results to come
    `SRR_ASSERT_IMP(a_busy_mid_request, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

endmodule

bind selective_repeat_reorder_receiver_core srr_chk u_srr_chk (.*);
